[hdl/udqs_pkg.sv]
// ----------------------------------------------------------------------------
// udqs_pkg
// Types and constants shared by the dash and quote substitution block.
// ----------------------------------------------------------------------------
package udqs_pkg;

  // Characters that start or extend a mark
  localparam logic [7:0] BYTE_DASH = 8'h2D;
  localparam logic [7:0] BYTE_BQ   = 8'h60;
  localparam logic [7:0] BYTE_APOS = 8'h27;

  // UTF-8 punctuation: every sequence is E2 80 xx, only the tail differs
  localparam logic [7:0] UTF8_LEAD = 8'hE2;
  localparam logic [7:0] UTF8_CONT = 8'h80;
  localparam logic [7:0] TAIL_EM   = 8'h94;
  localparam logic [7:0] TAIL_EN   = 8'h93;
  localparam logic [7:0] TAIL_LDQ  = 8'h9C;
  localparam logic [7:0] TAIL_LSQ  = 8'h98;
  localparam logic [7:0] TAIL_RDQ  = 8'h9D;
  localparam logic [7:0] TAIL_RSQ  = 8'h99;

  // Pending mark codes
  localparam logic [2:0] MARK_NONE  = 3'd0;
  localparam logic [2:0] MARK_DASH1 = 3'd1;
  localparam logic [2:0] MARK_DASH2 = 3'd2;
  localparam logic [2:0] MARK_BQ    = 3'd3;
  localparam logic [2:0] MARK_APOS  = 3'd4;

  // Token queue geometry
  localparam int unsigned TOK_DEPTH = 4;
  localparam int unsigned TOK_PTR_W = 2;
  localparam int unsigned TOK_CNT_W = 3;

  // Byte position inside a three-byte sequence
  localparam logic [1:0] POS_LEAD = 2'd0;
  localparam logic [1:0] POS_CONT = 2'd1;
  localparam logic [1:0] POS_TAIL = 2'd2;

  // One output token: a plain byte, or a UTF-8 sequence given by its tail
  typedef struct packed {
    logic       seq;
    logic [7:0] data;
    logic       fin;
  } tok_t;

  // Up to two tokens written into the queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       tok0;
    tok_t       tok1;
  } push_t;

endpackage

[hdl/udqs_in_if.sv]
// ----------------------------------------------------------------------------
// udqs_in_if
// Input channel: one text byte per transaction, flag on the final byte.
// ----------------------------------------------------------------------------
interface udqs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

[hdl/udqs_out_if.sv]
// ----------------------------------------------------------------------------
// udqs_out_if
// Output channel: one output byte per transaction, flag on the last byte.
// ----------------------------------------------------------------------------
interface udqs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       final_out;

  modport source (output valid, output out_byte, output final_out, input ready);
  modport sink   (input valid, input out_byte, input final_out, output ready);
endinterface

[hdl/utf8_dash_quote_substitute.sv]
// ----------------------------------------------------------------------------
// utf8_dash_quote_substitute
// Rewrites typewriter dashes and quotes in a byte stream as UTF-8 punctuation.
//
//   Channel   Dir   Payload                  Transaction
//   in_i      in    in_byte, end_of_text     one text byte
//   out_o     out   out_byte, final_out      one output byte
//
// An input byte is classified in the cycle it is accepted and yields up to
// two tokens (plain byte or three-byte sequence) in a four-entry queue.
// The back end sends one byte per cycle while the output is not stalled, so
// an input byte yields zero to six output bytes; sustained rate is set by the
// one-byte output port. Input stalls only when the queue has fewer than two
// free entries. Reset clears the pending mark, queue and output valid; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_dash_quote_substitute (
  input  logic       clk_i,
  input  logic       rst_ni,
  udqs_in_if.sink    in_i,
  udqs_out_if.source out_o
);

  udqs_pkg::push_t push;
  udqs_pkg::tok_t  head;
  logic            empty;
  logic            space;
  logic            pop;

  udqs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .in_byte_i     (in_i.in_byte),
    .end_of_text_i (in_i.end_of_text),
    .space_i       (space),
    .push_o        (push)
  );

  udqs_tok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .space_o (space)
  );

  udqs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .final_out_o (out_o.final_out)
  );

endmodule

[hdl/udqs_front.sv]
// ----------------------------------------------------------------------------
// udqs_front
// Classifies each input byte against the pending mark and emits up to two
// output tokens into the token queue.
// ----------------------------------------------------------------------------
module udqs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 end_of_text_i,
  input  logic                 space_i,
  output udqs_pkg::push_t      push_o
);

  logic [2:0]      pend_q, pend_d;
  logic [2:0]      mark_n;
  logic            accept;
  logic            fresh;
  logic            a_vld, b_vld;
  udqs_pkg::tok_t  a_tok, b_tok;
  udqs_pkg::push_t push;

  // Short form of a mark when it is not extended
  function automatic udqs_pkg::tok_t short_tok(input logic [2:0] mark);
    udqs_pkg::tok_t t;
    t.fin = 1'b0;
    case (mark)
      udqs_pkg::MARK_DASH1: begin t.seq = 1'b0; t.data = udqs_pkg::BYTE_DASH; end
      udqs_pkg::MARK_DASH2: begin t.seq = 1'b1; t.data = udqs_pkg::TAIL_EN;   end
      udqs_pkg::MARK_BQ:    begin t.seq = 1'b1; t.data = udqs_pkg::TAIL_LSQ;  end
      udqs_pkg::MARK_APOS:  begin t.seq = 1'b1; t.data = udqs_pkg::TAIL_RSQ;  end
      default:              begin t.seq = 1'b0; t.data = '0;                  end
    endcase
    return t;
  endfunction

  function automatic udqs_pkg::tok_t seq_tok(input logic [7:0] tail);
    udqs_pkg::tok_t t;
    t.seq  = 1'b1;
    t.data = tail;
    t.fin  = 1'b0;
    return t;
  endfunction

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;

  always_comb begin
    a_vld  = 1'b0;
    a_tok  = '0;
    b_vld  = 1'b0;
    b_tok  = '0;
    fresh  = 1'b0;
    mark_n = udqs_pkg::MARK_NONE;

    // Resolve the lookahead first
    case (pend_q)
      udqs_pkg::MARK_DASH1: begin
        if (in_byte_i == udqs_pkg::BYTE_DASH) begin
          mark_n = udqs_pkg::MARK_DASH2;
        end else begin
          a_vld = 1'b1;
          a_tok = short_tok(pend_q);
          fresh = 1'b1;
        end
      end
      udqs_pkg::MARK_DASH2: begin
        if (in_byte_i == udqs_pkg::BYTE_DASH) begin
          a_vld = 1'b1;
          a_tok = seq_tok(udqs_pkg::TAIL_EM);
        end else begin
          a_vld = 1'b1;
          a_tok = short_tok(pend_q);
          fresh = 1'b1;
        end
      end
      udqs_pkg::MARK_BQ: begin
        if (in_byte_i == udqs_pkg::BYTE_BQ) begin
          a_vld = 1'b1;
          a_tok = seq_tok(udqs_pkg::TAIL_LDQ);
        end else begin
          a_vld = 1'b1;
          a_tok = short_tok(pend_q);
          fresh = 1'b1;
        end
      end
      udqs_pkg::MARK_APOS: begin
        if (in_byte_i == udqs_pkg::BYTE_APOS) begin
          a_vld = 1'b1;
          a_tok = seq_tok(udqs_pkg::TAIL_RDQ);
        end else begin
          a_vld = 1'b1;
          a_tok = short_tok(pend_q);
          fresh = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // Handle the byte as if nothing were pending
    if (fresh) begin
      if (in_byte_i == udqs_pkg::BYTE_DASH) begin
        mark_n = udqs_pkg::MARK_DASH1;
      end else if (in_byte_i == udqs_pkg::BYTE_BQ) begin
        mark_n = udqs_pkg::MARK_BQ;
      end else if (in_byte_i == udqs_pkg::BYTE_APOS) begin
        mark_n = udqs_pkg::MARK_APOS;
      end else begin
        b_vld      = 1'b1;
        b_tok.seq  = 1'b0;
        b_tok.data = in_byte_i;
        b_tok.fin  = 1'b0;
      end
    end

    // Flush at end of text; a plain byte and a new mark never both occur
    pend_d = mark_n;
    if (end_of_text_i && (mark_n != udqs_pkg::MARK_NONE)) begin
      b_vld  = 1'b1;
      b_tok  = short_tok(mark_n);
      pend_d = udqs_pkg::MARK_NONE;
    end

    // Pack the tokens into the lowest slots and tag the last one
    push = '0;
    if (a_vld) begin
      push.tok0 = a_tok;
      push.tok1 = b_tok;
      push.cnt  = b_vld ? 2'd2 : 2'd1;
      if (b_vld) begin
        push.tok1.fin = end_of_text_i;
      end else begin
        push.tok0.fin = end_of_text_i;
      end
    end else if (b_vld) begin
      push.tok0     = b_tok;
      push.tok0.fin = end_of_text_i;
      push.cnt      = 2'd1;
    end
    if (!accept) begin
      push.cnt = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= udqs_pkg::MARK_NONE;
    end else if (accept) begin
      pend_q <= pend_d;
    end
  end

endmodule

[hdl/udqs_tok_fifo.sv]
// ----------------------------------------------------------------------------
// udqs_tok_fifo
// Short token queue between front and back: up to two writes and one read
// per cycle.
// ----------------------------------------------------------------------------
module udqs_tok_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  udqs_pkg::push_t push_i,
  input  logic            pop_i,
  output udqs_pkg::tok_t  head_o,
  output logic            empty_o,
  output logic            space_o
);

  udqs_pkg::tok_t                   mem_q [udqs_pkg::TOK_DEPTH];
  logic [udqs_pkg::TOK_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [udqs_pkg::TOK_PTR_W-1:0]   wr_ptr1;
  logic [udqs_pkg::TOK_CNT_W-1:0]   count_q;
  logic                             do_pop;

  assign wr_ptr1 = wr_ptr_q + 1'b1;
  assign empty_o = (count_q == '0);
  assign space_o = (count_q <= udqs_pkg::TOK_CNT_W'(udqs_pkg::TOK_DEPTH - 2));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.tok0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr1] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + udqs_pkg::TOK_PTR_W'(push_i.cnt);
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + udqs_pkg::TOK_CNT_W'(push_i.cnt)
                 - udqs_pkg::TOK_CNT_W'(do_pop);
    end
  end

endmodule

[hdl/udqs_back.sv]
// ----------------------------------------------------------------------------
// udqs_back
// Serialises tokens into output bytes through the output register, one byte
// per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module udqs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  udqs_pkg::tok_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           final_out_o
);

  logic [1:0] pos_q;
  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic       fin_q;
  logic       load;
  logic       tok_done;

  assign load     = !empty_i && (!valid_q || out_ready_i);
  assign tok_done = !head_i.seq || (pos_q == udqs_pkg::POS_TAIL);
  assign pop_o    = load && tok_done;

  always_comb begin
    if (!head_i.seq) begin
      byte_d = head_i.data;
    end else begin
      case (pos_q)
        udqs_pkg::POS_LEAD: byte_d = udqs_pkg::UTF8_LEAD;
        udqs_pkg::POS_CONT: byte_d = udqs_pkg::UTF8_CONT;
        default:            byte_d = head_i.data;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= udqs_pkg::POS_LEAD;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        pos_q   <= tok_done ? udqs_pkg::POS_LEAD : pos_q + 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Payload holds while the output stalls
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      fin_q  <= head_i.fin && tok_done;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign final_out_o = fin_q;

endmodule

[hdl/udqs_checker.sv]
// ----------------------------------------------------------------------------
// udqs_checker
// Port-level checks on the substitution block, bound to the top level.
// ----------------------------------------------------------------------------
module udqs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       end_of_text_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       final_out_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A stalled output byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
                                    && $stable(final_out_i))
    else $error("output changed while stalled");

  // Output is idle straight after reset
  a_reset_idle: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_i)
    else $error("output valid after reset");

  // An idle output that follows an idle output with no input accepted means the queue has drained
  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && $past(!out_valid_i) && $past(!in_acc) |-> in_ready_i)
    else $error("input not ready with drained queue");

  // The final byte of a text into an idle block always produces output
  a_eot_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_of_text_i && !out_valid_i && $past(!out_valid_i)
    && $past(!in_acc) |-> ##2 out_valid_i)
    else $error("end of text produced no output");

endmodule

bind utf8_dash_quote_substitute udqs_checker u_udqs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .end_of_text_i (in_i.end_of_text),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .final_out_i   (out_o.final_out)
);
